// ===== hw/rtl/bpk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package bpk_pkg;

  localparam int VALUE_W           = 64;
  localparam int BIT_COUNT_W       = 7;
  localparam int BYTE_W            = 8;
  localparam int HELD_COUNT_W      = 3;
  localparam int BYTE_COUNT_W      = 4;   // holds 0..8 bytes per item
  localparam int STREAM_W          = VALUE_W + BYTE_W;
  localparam int TOTAL_COUNT_WIDTH = 48;  // running emitted-bit counter, wraps
  localparam int TOTAL_BITS_W      = 48;  // width of the reported total

  localparam logic [BIT_COUNT_W-1:0]  MAX_FIELD_BITS = 7'd64;
  localparam logic [BYTE_COUNT_W-1:0] ONE_BYTE       = 4'd1;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_FLUSH  = 1'b1
  } func_t;

  // Outcome of packing one item against the held bits.
  typedef struct packed {
    logic [VALUE_W-1:0]      bytes;       // bytes to emit, earliest in the top byte
    logic [BYTE_COUNT_W-1:0] count;       // results to deliver, 1..8
    logic                    byte_valid;
    logic [BIT_COUNT_W-1:0]  add_bits;    // bits emitted by this item
    logic [BYTE_W-1:0]       held_bits;
    logic [HELD_COUNT_W-1:0] held_count;
  } pack_t;

  // Load into the output serializer.
  typedef struct packed {
    logic [VALUE_W-1:0]      bytes;
    logic [BYTE_COUNT_W-1:0] count;
    logic                    byte_valid;
    logic [TOTAL_BITS_W-1:0] total_bits;
    logic                    aligned;
  } emit_load_t;

endpackage

// ===== hw/rtl/bpk_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_pack
// Combines the held bits with one item and splits the result into whole
// bytes and a new left-aligned remainder.
// ----------------------------------------------------------------------------
module bpk_pack import bpk_pkg::*; (
  input  logic                    func,
  input  logic [VALUE_W-1:0]      value,
  input  logic [BIT_COUNT_W-1:0]  bit_count,
  input  logic [BYTE_W-1:0]       held_bits,
  input  logic [HELD_COUNT_W-1:0] held_count,
  output pack_t                   result
);

  logic [BIT_COUNT_W-1:0]  n;
  logic [VALUE_W-1:0]      value_left;
  logic [STREAM_W-1:0]     stream;
  logic [STREAM_W-1:0]     stream_rest;
  logic [BIT_COUNT_W-1:0]  total;
  logic [BYTE_COUNT_W-1:0] nbytes;

  always_comb begin
    n = (bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : bit_count;
    // Left-justify the field; bits above n fall off the top.
    value_left  = value << (MAX_FIELD_BITS - n);
    stream      = {held_bits, {VALUE_W{1'b0}}} | ({value_left, {BYTE_W{1'b0}}} >> held_count);
    total       = BIT_COUNT_W'(held_count) + n;
    nbytes      = total[BIT_COUNT_W-1:HELD_COUNT_W];
    stream_rest = stream << {nbytes, 3'b000};

    result = '0;
    if (func == FUNC_FLUSH) begin
      result.count = ONE_BYTE;
      if (held_count == '0) begin
        // Nothing to pad: keep state as is.
        result.held_bits  = held_bits;
        result.held_count = held_count;
      end else begin
        result.bytes      = {held_bits, {(VALUE_W-BYTE_W){1'b0}}};
        result.byte_valid = 1'b1;
        result.add_bits   = BIT_COUNT_W'(BYTE_W);
      end
    end else begin
      result.held_bits  = stream_rest[STREAM_W-1 -: BYTE_W];
      result.held_count = total[HELD_COUNT_W-1:0];
      result.add_bits   = {nbytes, 3'b000};
      if (nbytes == '0) begin
        result.count = ONE_BYTE;
      end else begin
        result.bytes      = stream[STREAM_W-1 -: VALUE_W];
        result.count      = nbytes;
        result.byte_valid = 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/bpk_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_emit
// Output register that delivers the bytes of one item, one per transaction.
// ----------------------------------------------------------------------------
module bpk_emit import bpk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  emit_load_t              load_data,
  output logic                    ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    byte_valid,
  output logic [BYTE_W-1:0]       out_byte,
  output logic                    last,
  output logic [TOTAL_BITS_W-1:0] total_bits,
  output logic                    aligned
);

  logic [VALUE_W-1:0]      bytes;
  logic [BYTE_COUNT_W-1:0] count;
  logic                    take;

  assign take  = out_valid && !out_stall;
  assign last  = (count == ONE_BYTE);
  assign ready = !out_valid || (take && last);

  assign out_byte = bytes[VALUE_W-1 -: BYTE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (take && last) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: load a fresh item or advance to the next byte.
  always_ff @(posedge clk) begin
    if (load) begin
      bytes      <= load_data.bytes;
      count      <= load_data.count;
      byte_valid <= load_data.byte_valid;
      total_bits <= load_data.total_bits;
      aligned    <= load_data.aligned;
    end else if (take) begin
      bytes <= bytes << BYTE_W;
      count <= count - ONE_BYTE;
    end
  end

endmodule

// ===== hw/rtl/msb_first_bit_packer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// MSB-first bit packer: appends 0..64-bit fields to a byte stream.
// ----------------------------------------------------------------------------
// An accepted transaction is held in an input register, packed against the
// held bits combinationally from that register, and loaded into the output
// register once that register is ready. An append or flush that yields one
// result streams at one per clock while the output side is not stalled. An
// append that completes k bytes (k up to 8) holds the output register until
// its last byte is taken, one byte per output transaction, while a following
// item waits in the input register with stall raised toward the input. A
// stall on the output side holds the result and backs up into the input
// register. Every result of an item carries the total bit count and
// alignment after that item; an item that completes no byte gives one
// result with byte_valid low. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unit import bpk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic [VALUE_W-1:0]      value,
  input  logic [BIT_COUNT_W-1:0]  bit_count,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    byte_valid,
  output logic [BYTE_W-1:0]       out_byte,
  output logic                    last,
  output logic [TOTAL_BITS_W-1:0] total_bits,
  output logic                    aligned
);

  // Input register
  logic                   in_valid_q;
  logic                   func_q;
  logic [VALUE_W-1:0]     value_q;
  logic [BIT_COUNT_W-1:0] bit_count_q;

  // Stream state
  logic [BYTE_W-1:0]            held_bits;
  logic [HELD_COUNT_W-1:0]      held_count;
  logic [TOTAL_COUNT_WIDTH-1:0] emitted_bit_count;
  logic [TOTAL_COUNT_WIDTH-1:0] emitted_bit_count_next;
  logic [TOTAL_COUNT_WIDTH-1:0] total_sum;

  pack_t      packed_item;
  emit_load_t load_data;
  logic       emit_ready;
  logic       load;

  // Advance the held transaction once the output register can take it.
  assign load     = in_valid_q && emit_ready;
  assign in_stall = in_valid_q && !emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q      <= func;
      value_q     <= value;
      bit_count_q <= bit_count;
    end
  end

  bpk_pack u_pack (
    .func       (func_q),
    .value      (value_q),
    .bit_count  (bit_count_q),
    .held_bits  (held_bits),
    .held_count (held_count),
    .result     (packed_item)
  );

  // Counter wraps at its own width; the reported total is cut or extended.
  assign emitted_bit_count_next = emitted_bit_count
                                + TOTAL_COUNT_WIDTH'(packed_item.add_bits);
  assign total_sum = emitted_bit_count_next + TOTAL_COUNT_WIDTH'(packed_item.held_count);

  always_comb begin
    load_data.bytes      = packed_item.bytes;
    load_data.count      = packed_item.count;
    load_data.byte_valid = packed_item.byte_valid;
    load_data.total_bits = TOTAL_BITS_W'(total_sum);
    load_data.aligned    = (packed_item.held_count == '0);
  end

  // Commit the new stream state as the item moves to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bits         <= '0;
      held_count        <= '0;
      emitted_bit_count <= '0;
    end else if (load) begin
      held_bits         <= packed_item.held_bits;
      held_count        <= packed_item.held_count;
      emitted_bit_count <= emitted_bit_count_next;
    end
  end

  bpk_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_data  (load_data),
    .ready      (emit_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_valid (byte_valid),
    .out_byte   (out_byte),
    .last       (last),
    .total_bits (total_bits),
    .aligned    (aligned)
  );

endmodule

// ===== hw/rtl/bpk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpk_checker
// Port-level checks for the MSB-first bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module bpk_checker import bpk_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    byte_valid,
  input logic [BYTE_W-1:0]       out_byte,
  input logic                    last,
  input logic [TOTAL_BITS_W-1:0] total_bits,
  input logic                    aligned
);

  // Nothing is pending right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last)
                               && $stable(byte_valid))
    else $error("stalled result changed");

  // Emitted bits come in whole bytes, so alignment matches the total.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (aligned == (total_bits[2:0] == 3'd0)))
    else $error("aligned disagrees with total_bits");

  // An empty result is always the only result of its item.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && (out_byte == '0))
    else $error("empty result not final or not zero");

  // The bytes of one item follow each other and share one total.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && byte_valid && $stable(total_bits)
                                        && $stable(aligned))
    else $error("multi-byte item broken up");

endmodule

bind msb_first_bit_packer_unit bpk_checker u_bpk_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .byte_valid (byte_valid),
  .out_byte   (out_byte),
  .last       (last),
  .total_bits (total_bits),
  .aligned    (aligned)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MSB-first bit packer.
// ----------------------------------------------------------------------------
// Drives appends and flushes through the valid/stall input channel and checks
// every output transaction against a bit-accurate predictor of the packed
// stream: emitted bytes, the last flag, the running total bit count and the
// alignment flag. A short directed sequence hits the corner cases first; a
// long random sequence follows, with random idle bursts on the input and stall
// bursts on the output, one full drain pause in the middle, and a calm tail.
// ----------------------------------------------------------------------------

module tb_top;
  import bpk_pkg::*;

  // One expected output transaction.
  typedef struct packed {
    logic                    byte_valid;
    logic [BYTE_W-1:0]       out_byte;
    logic                    last;
    logic [TOTAL_BITS_W-1:0] total_bits;
    logic                    aligned;
  } byte_result_t;

  // Tracks the packed stream and the bytes it must produce, in order.
  class packed_byte_tracker;
    logic [BYTE_W-1:0]            held_bits;
    logic [HELD_COUNT_W-1:0]      held_count;
    logic [TOTAL_COUNT_WIDTH-1:0] emitted_bits;
    byte_result_t                 pending_bytes[$];
    int errors;
    int appends;
    int flushes;
    int bytes_checked;
    int full_appends;

    function new();
      held_bits     = '0;
      held_count    = '0;
      emitted_bits  = '0;
      errors        = 0;
      appends       = 0;
      flushes       = 0;
      bytes_checked = 0;
      full_appends  = 0;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    // Queue one result, stamped with the stream totals after the item.
    function void queue_byte(logic valid, logic [BYTE_W-1:0] b, logic is_last);
      byte_result_t r;
      r.byte_valid = valid;
      r.out_byte   = b;
      r.last       = is_last;
      r.total_bits = TOTAL_BITS_W'(emitted_bits + TOTAL_COUNT_WIDTH'(held_count));
      r.aligned    = (held_count == '0);
      pending_bytes.push_back(r);
    endfunction

    // Advance the stream by one accepted input transaction.
    function void note_field(func_t f, logic [VALUE_W-1:0] v,
                             logic [BIT_COUNT_W-1:0] n);
      logic [STREAM_W-1:0] stream;
      logic [VALUE_W-1:0]  field;
      logic [BYTE_W-1:0]   flushed;
      logic [BYTE_W-1:0]   out_bytes[8];
      int nbits;
      int hc;
      int nbytes;
      if (f == FUNC_FLUSH) begin
        flushes++;
        if (held_count == '0) begin
          queue_byte(1'b0, '0, 1'b1);
        end else begin
          flushed      = held_bits;
          held_bits    = '0;
          held_count   = '0;
          emitted_bits = emitted_bits + TOTAL_COUNT_WIDTH'(BYTE_W);
          queue_byte(1'b1, flushed, 1'b1);
        end
        return;
      end
      appends++;
      // Clamp oversized counts and drop value bits above the count.
      nbits = (n > MAX_FIELD_BITS) ? VALUE_W : int'(n);
      field = (nbits == VALUE_W) ? v : (v & ((64'd1 << nbits) - 64'd1));
      hc    = int'(held_count);
      // Left-align held bits then field bits in one 72-bit window.
      stream = {held_bits, {VALUE_W{1'b0}}} |
               (STREAM_W'(field) << (STREAM_W - hc - nbits));
      nbytes = (hc + nbits) / BYTE_W;
      for (int k = 0; k < nbytes; k++)
        out_bytes[k] = stream[STREAM_W-1-BYTE_W*k -: BYTE_W];
      held_bits    = stream[STREAM_W-1-BYTE_W*nbytes -: BYTE_W];
      held_count   = HELD_COUNT_W'((hc + nbits) % BYTE_W);
      emitted_bits = emitted_bits + TOTAL_COUNT_WIDTH'(nbytes * BYTE_W);
      if (nbytes == 8)
        full_appends++;
      if (nbytes == 0)
        queue_byte(1'b0, '0, 1'b1);
      for (int k = 0; k < nbytes; k++)
        queue_byte(1'b1, out_bytes[k], k == nbytes - 1);
    endfunction

    // Compare one output transaction with the oldest expectation.
    function void check_byte(byte_result_t got);
      byte_result_t want;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte_valid=%0b out_byte=%02h last=%0b",
                 $time, got.byte_valid, got.out_byte, got.last);
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected valid=%0b byte=%02h last=%0b total=%0d aligned=%0b",
                 $time, want.byte_valid, want.out_byte, want.last, want.total_bits,
                 want.aligned);
        $display("%0t:          actual   valid=%0b byte=%02h last=%0b total=%0d aligned=%0b",
                 $time, got.byte_valid, got.out_byte, got.last, got.total_bits,
                 got.aligned);
      end
    endfunction
  endclass

  localparam int RANDOM_FIELDS = 290;
  localparam int CALM_TAIL     = 40;
  localparam int DRAIN_AT      = 140;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    func = FUNC_APPEND;
  logic [VALUE_W-1:0]      value = '0;
  logic [BIT_COUNT_W-1:0]  bit_count = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    byte_valid;
  logic [BYTE_W-1:0]       out_byte;
  logic                    last;
  logic [TOTAL_BITS_W-1:0] total_bits;
  logic                    aligned;

  // Idle and stall bursts are started only while this is set.
  logic                    bursts_on = 1'b1;
  int                      stall_left = 0;

  packed_byte_tracker sb = new();

  msb_first_bit_packer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .value      (value),
    .bit_count  (bit_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_valid (byte_valid),
    .out_byte   (out_byte),
    .last       (last),
    .total_bits (total_bits),
    .aligned    (aligned)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: check each accepted transaction using the values from before
  // the edge, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_byte('{byte_valid, out_byte, last, total_bits, aligned});
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        // Start a stall burst of random length.
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one transaction and hold it until the block takes it.
  task automatic send_field(func_t f, logic [VALUE_W-1:0] v,
                            logic [BIT_COUNT_W-1:0] n);
    in_valid  <= 1'b1;
    func      <= f;
    value     <= v;
    bit_count <= n;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_field(f, v, n);
  endtask

  // Drop valid for the given number of cycles.
  task automatic idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the sender until every expected byte has come out.
  task automatic drain_output();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (sb.pending() != 0);
  endtask

  // Mostly in-range appends with random content; some flushes and some
  // oversized counts that must clamp to 64.
  task automatic send_random_field();
    logic [VALUE_W-1:0] v;
    int pick;
    v    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (bursts_on && $urandom_range(0, 3) == 0)
      idle_input($urandom_range(1, 3));
    if (pick < 14)
      send_field(FUNC_FLUSH, v, BIT_COUNT_W'($urandom_range(0, 127)));
    else if (pick < 22)
      send_field(FUNC_APPEND, v, BIT_COUNT_W'($urandom_range(65, 127)));
    else if (pick < 50)
      send_field(FUNC_APPEND, v, BIT_COUNT_W'($urandom_range(0, 9)));
    else
      send_field(FUNC_APPEND, v, BIT_COUNT_W'($urandom_range(0, 64)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: empty flush, zero-length field, full 64-bit fields,
    // garbage above the count, clamped counts, and eight bytes from one item.
    send_field(FUNC_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    send_field(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    send_field(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
    send_field(FUNC_APPEND, 64'h0000_0000_0000_0000, 7'd64);
    send_field(FUNC_APPEND, 64'h0000_0000_0000_0001, 7'd1);
    send_field(FUNC_APPEND, 64'hDEAD_BEEF_0000_0055, 7'd7);
    send_field(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3);
    send_field(FUNC_FLUSH,  64'h0, 7'd0);
    send_field(FUNC_APPEND, 64'h0123_4567_89AB_CDEF, 7'd7);
    send_field(FUNC_APPEND, 64'hA5C3_0FF0_5A3C_F00F, 7'd64);
    send_field(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
    send_field(FUNC_APPEND, 64'h8000_0000_0000_0001, 7'd65);
    send_field(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd8);
    send_field(FUNC_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
    send_field(FUNC_FLUSH,  64'h0, 7'd64);
    send_field(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_E5A5, 7'd13);
    send_field(FUNC_APPEND, 64'h8000_0000_0000_0000, 7'd63);
    send_field(FUNC_APPEND, 64'h8000_0000_0000_0001, 7'd64);
    send_field(FUNC_FLUSH,  64'h0, 7'd0);
    send_field(FUNC_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64);
    send_field(FUNC_APPEND, 64'h5555_5555_5555_5555, 7'd66);

    // Random part in segments of 50; about a third of them run without bursts.
    for (int i = 0; i < RANDOM_FIELDS; i++) begin
      if (i == DRAIN_AT)
        drain_output();
      if (i >= RANDOM_FIELDS - CALM_TAIL)
        bursts_on <= 1'b0;
      else if (i % 50 == 0)
        bursts_on <= ($urandom_range(0, 2) != 0);
      send_random_field();
    end
    in_valid <= 1'b0;

    // Drain, then give any stray transaction time to show up.
    do
      @(posedge clk);
    while (sb.pending() != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d appends (%0d producing eight bytes) and %0d flushes,",
             sb.appends, sb.full_appends, sb.flushes);
    $display("with %0d output transactions checked under random idle and stall.",
             sb.bytes_checked);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bpk_pkg.sv
hw/rtl/bpk_pack.sv
hw/rtl/bpk_emit.sv
hw/rtl/msb_first_bit_packer_unit.sv
hw/rtl/bpk_checker.sv
test/tb_top.sv
